// File: sv/base3_mask_base57_digit_filter_core_macros.svh
// Assertion macros shared by the checker files.
`ifndef BASE3_MASK_BASE57_DIGIT_FILTER_CORE_MACROS_SVH
`define BASE3_MASK_BASE57_DIGIT_FILTER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define B3M_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define B3M_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/b3m_pkg.sv
`default_nettype none

package b3m_pkg;

  // Field widths
  localparam int MASK_W     = 24;
  localparam int VALUE_W    = 38;
  localparam int DIGITS_DEF = 24;

  // Largest value a full mask can produce: (3^24 - 1) / 2
  localparam logic [VALUE_W-1:0] VALUE_MAX = 38'd141214768240;

  // Radix-125 limbs hold three base-5 digits, radix-49 limbs two base-7 digits
  localparam int BASE5   = 5;
  localparam int BASE7   = 7;
  localparam int LIM5    = 2;
  localparam int LIM7    = 3;
  localparam int RAD5    = BASE5 * BASE5 * BASE5;
  localparam int RAD7    = BASE7 * BASE7;
  localparam int LIMB5_W = $clog2(RAD5);
  localparam int LIMB7_W = $clog2(RAD7);
  localparam int NLIMB   = 7;

  // Term grouping for the first adder stage
  localparam int GRP_SZ = 6;
  localparam int GRP_N  = (MASK_W + GRP_SZ - 1) / GRP_SZ;
  localparam int GRP_W  = $clog2((RAD5 - 1) * GRP_SZ + 1);

  // Column sums and the carry between limbs
  localparam int QMAX    = MASK_W;
  localparam int CARRY_W = $clog2(QMAX + 1);
  localparam int SUM_W   = $clog2((QMAX + 1) * RAD5);

  typedef logic [MASK_W-1:0][VALUE_W-1:0]             pow3_tab_t;
  typedef logic [MASK_W-1:0][NLIMB-1:0][LIMB5_W-1:0]  limb5_tab_t;
  typedef logic [MASK_W-1:0][NLIMB-1:0][LIMB7_W-1:0]  limb7_tab_t;
  typedef logic [RAD5-1:0]                            ok5_tab_t;
  typedef logic [RAD7-1:0]                            ok7_tab_t;
  typedef logic [QMAX:0][SUM_W-1:0]                   mul_tab_t;

  // One pipeline slot after the adder tree
  typedef struct packed {
    logic                          vld;
    logic                          drop;
    logic                          ok;
    logic [VALUE_W-1:0]            n;
    logic [NLIMB-1:0][SUM_W-1:0]   s5;
    logic [NLIMB-1:0][SUM_W-1:0]   s7;
    logic [CARRY_W-1:0]            c5;
    logic [CARRY_W-1:0]            c7;
  } stage_t;

  // Powers of three in binary
  function automatic pow3_tab_t build_pow3();
    pow3_tab_t          t;
    logic [VALUE_W-1:0] p;
    p = VALUE_W'(1);
    for (int i = 0; i < MASK_W; i++) begin
      t[i] = p;
      p    = p * VALUE_W'(3);
    end
    return t;
  endfunction

  // Powers of three split into radix-125 limbs
  function automatic limb5_tab_t build_limb5();
    limb5_tab_t t;
    longint     p;
    longint     q;
    p = 1;
    for (int i = 0; i < MASK_W; i++) begin
      for (int j = 0; j < NLIMB; j++) begin
        q = p;
        for (int k = 0; k < j; k++) q = q / RAD5;
        t[i][j] = LIMB5_W'(q % RAD5);
      end
      p = p * 3;
    end
    return t;
  endfunction

  // Powers of three split into radix-49 limbs
  function automatic limb7_tab_t build_limb7();
    limb7_tab_t t;
    longint     p;
    longint     q;
    p = 1;
    for (int i = 0; i < MASK_W; i++) begin
      for (int j = 0; j < NLIMB; j++) begin
        q = p;
        for (int k = 0; k < j; k++) q = q / RAD7;
        t[i][j] = LIMB7_W'(q % RAD7);
      end
      p = p * 3;
    end
    return t;
  endfunction

  // Limb passes when each of its three base-5 digits is at most 2
  function automatic ok5_tab_t build_ok5();
    ok5_tab_t t;
    for (int d2 = 0; d2 < BASE5; d2++) begin
      for (int d1 = 0; d1 < BASE5; d1++) begin
        for (int d0 = 0; d0 < BASE5; d0++) begin
          t[(d2 * BASE5 + d1) * BASE5 + d0] = (d2 <= LIM5) && (d1 <= LIM5) && (d0 <= LIM5);
        end
      end
    end
    return t;
  endfunction

  // Limb passes when each of its two base-7 digits is at most 3
  function automatic ok7_tab_t build_ok7();
    ok7_tab_t t;
    for (int d1 = 0; d1 < BASE7; d1++) begin
      for (int d0 = 0; d0 < BASE7; d0++) begin
        t[d1 * BASE7 + d0] = (d1 <= LIM7) && (d0 <= LIM7);
      end
    end
    return t;
  endfunction

  // Multiples of the limb radix, used as quotient thresholds
  function automatic mul_tab_t build_mul5();
    mul_tab_t t;
    for (int q = 0; q <= QMAX; q++) t[q] = SUM_W'(q * RAD5);
    return t;
  endfunction

  function automatic mul_tab_t build_mul7();
    mul_tab_t t;
    for (int q = 0; q <= QMAX; q++) t[q] = SUM_W'(q * RAD7);
    return t;
  endfunction

  localparam pow3_tab_t  POW3  = build_pow3();
  localparam limb5_tab_t LIMB5 = build_limb5();
  localparam limb7_tab_t LIMB7 = build_limb7();
  localparam ok5_tab_t   OK5   = build_ok5();
  localparam ok7_tab_t   OK7   = build_ok7();
  localparam mul_tab_t   MUL5  = build_mul5();
  localparam mul_tab_t   MUL7  = build_mul7();

endpackage

`default_nettype wire

// File: sv/b3m_ifs.sv
`default_nettype none

// Candidate mask channel
interface b3m_cand_if;
  logic                         valid;
  logic                         ready;
  logic [b3m_pkg::MASK_W-1:0]   mask;

  modport source (output valid, output mask, input ready);
  modport sink   (input valid, input mask, output ready);
endinterface

// Accepted value channel
interface b3m_found_if;
  logic                         valid;
  logic                         ready;
  logic [b3m_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: sv/b3m_sum.sv
`default_nettype none

// Two-stage adder tree: binary value plus radix-125 and radix-49 column sums
module b3m_sum #(
  parameter int DIGITS = b3m_pkg::DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [b3m_pkg::MASK_W-1:0]  mask,
  output b3m_pkg::stage_t             st
);

  logic                                                            grp_vld;
  logic                                                            grp_drop;
  logic                                                            grp_drop_next;
  logic [b3m_pkg::GRP_N-1:0][b3m_pkg::VALUE_W-1:0]                 grp_n;
  logic [b3m_pkg::GRP_N-1:0][b3m_pkg::VALUE_W-1:0]                 grp_n_next;
  logic [b3m_pkg::GRP_N-1:0][b3m_pkg::NLIMB-1:0][b3m_pkg::GRP_W-1:0] grp_s5;
  logic [b3m_pkg::GRP_N-1:0][b3m_pkg::NLIMB-1:0][b3m_pkg::GRP_W-1:0] grp_s5_next;
  logic [b3m_pkg::GRP_N-1:0][b3m_pkg::NLIMB-1:0][b3m_pkg::GRP_W-1:0] grp_s7;
  logic [b3m_pkg::GRP_N-1:0][b3m_pkg::NLIMB-1:0][b3m_pkg::GRP_W-1:0] grp_s7_next;
  b3m_pkg::stage_t                                                 st_next;

  // Sum the set terms of each group; flag bits beyond the searched digits
  always_comb begin
    grp_n_next    = '0;
    grp_s5_next   = '0;
    grp_s7_next   = '0;
    grp_drop_next = 1'b0;
    for (int g = 0; g < b3m_pkg::GRP_N; g++) begin
      for (int t = 0; t < b3m_pkg::GRP_SZ; t++) begin
        if (g * b3m_pkg::GRP_SZ + t < b3m_pkg::MASK_W) begin
          if (mask[g * b3m_pkg::GRP_SZ + t]) begin
            if (g * b3m_pkg::GRP_SZ + t < DIGITS) begin
              grp_n_next[g] = grp_n_next[g] + b3m_pkg::POW3[g * b3m_pkg::GRP_SZ + t];
              for (int j = 0; j < b3m_pkg::NLIMB; j++) begin
                grp_s5_next[g][j] = grp_s5_next[g][j]
                  + b3m_pkg::GRP_W'(b3m_pkg::LIMB5[g * b3m_pkg::GRP_SZ + t][j]);
                grp_s7_next[g][j] = grp_s7_next[g][j]
                  + b3m_pkg::GRP_W'(b3m_pkg::LIMB7[g * b3m_pkg::GRP_SZ + t][j]);
              end
            end else begin
              grp_drop_next = 1'b1;
            end
          end
        end
      end
    end
  end

  // Hold group sums
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_vld <= 1'b0;
    end else if (en) begin
      grp_vld <= in_vld;
    end
    if (en) begin
      grp_drop <= grp_drop_next;
      grp_n    <= grp_n_next;
      grp_s5   <= grp_s5_next;
      grp_s7   <= grp_s7_next;
    end
  end

  // Merge the groups into one value and one column sum per limb
  always_comb begin
    st_next      = '0;
    st_next.vld  = grp_vld;
    st_next.drop = grp_drop;
    st_next.ok   = 1'b1;
    for (int g = 0; g < b3m_pkg::GRP_N; g++) begin
      st_next.n = st_next.n + grp_n[g];
      for (int j = 0; j < b3m_pkg::NLIMB; j++) begin
        st_next.s5[j] = st_next.s5[j] + b3m_pkg::SUM_W'(grp_s5[g][j]);
        st_next.s7[j] = st_next.s7[j] + b3m_pkg::SUM_W'(grp_s7[g][j]);
      end
    end
  end

  // Hold merged sums
  always_ff @(posedge clk) begin
    if (rst) begin
      st.vld <= 1'b0;
    end else if (en) begin
      st <= st_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/b3m_norm.sv
`default_nettype none

// One carry step: resolve limb K in both radices and check its digits
module b3m_norm #(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  b3m_pkg::stage_t  di,
  output b3m_pkg::stage_t  dq
);

  logic [b3m_pkg::SUM_W-1:0]   x5;
  logic [b3m_pkg::SUM_W-1:0]   x7;
  logic [b3m_pkg::SUM_W-1:0]   r5;
  logic [b3m_pkg::SUM_W-1:0]   r7;
  logic [b3m_pkg::QMAX:1]      thr5;
  logic [b3m_pkg::QMAX:1]      thr7;
  logic [b3m_pkg::CARRY_W-1:0] q5;
  logic [b3m_pkg::CARRY_W-1:0] q7;
  logic                        ok5;
  logic                        ok7;
  b3m_pkg::stage_t             dq_next;

  // Add incoming carry, split into digit and carry out by threshold compare
  always_comb begin
    x5 = di.s5[K] + b3m_pkg::SUM_W'(di.c5);
    x7 = di.s7[K] + b3m_pkg::SUM_W'(di.c7);
    for (int k = 1; k <= b3m_pkg::QMAX; k++) begin
      thr5[k] = (x5 >= b3m_pkg::MUL5[k]);
      thr7[k] = (x7 >= b3m_pkg::MUL7[k]);
    end
    q5  = b3m_pkg::CARRY_W'($countones(thr5));
    q7  = b3m_pkg::CARRY_W'($countones(thr7));
    r5  = x5 - b3m_pkg::MUL5[q5];
    r7  = x7 - b3m_pkg::MUL7[q7];
    ok5 = b3m_pkg::OK5[r5[b3m_pkg::LIMB5_W-1:0]];
    ok7 = b3m_pkg::OK7[r7[b3m_pkg::LIMB7_W-1:0]];

    dq_next    = di;
    dq_next.c5 = q5;
    dq_next.c7 = q7;
    dq_next.ok = di.ok & ok5 & ok7;
  end

  // Advance the slot
  always_ff @(posedge clk) begin
    if (rst) begin
      dq.vld <= 1'b0;
    end else if (en) begin
      dq <= dq_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/base3_mask_base57_digit_filter_core.sv
`default_nettype none

// Channel  Dir  Payload              Meaning
// cand     in   mask   [23:0]        base-3 digit mask of a candidate
// found    out  value  [37:0]        candidate whose base-5 and base-7 digits pass
//
// One mask per cycle unless the output stalls. Stages: two adder stages, seven
// carry stages (one per limb, set by the radix-49 limb count), one output register.
// Masks that fail either check, or set a bit at or above DIGITS, leave nothing.
// rst clears all valid bits; cand.ready is low during reset.
// A stalled output freezes every stage at once; nothing is lost or repeated.
module base3_mask_base57_digit_filter_core #(
  parameter int DIGITS = b3m_pkg::DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  b3m_cand_if.sink      cand,
  b3m_found_if.source   found
);

  logic                         adv;
  logic                         out_vld;
  logic [b3m_pkg::VALUE_W-1:0]  out_value;
  b3m_pkg::stage_t              chain [b3m_pkg::NLIMB+1];

  // Move the whole pipeline whenever the output slot is free or drained
  assign adv        = !out_vld || found.ready;
  assign cand.ready = adv && !rst;

  b3m_sum #(
    .DIGITS (DIGITS)
  ) u_sum (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .in_vld (cand.valid && !rst),
    .mask   (cand.mask),
    .st     (chain[0])
  );

  // Resolve carries limb by limb
  for (genvar k = 0; k < b3m_pkg::NLIMB; k++) begin : g_norm
    b3m_norm #(
      .K (k)
    ) u_norm (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .di  (chain[k]),
      .dq  (chain[k+1])
    );
  end

  // Output register: keep passing values, drop the rest
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= chain[b3m_pkg::NLIMB].vld && chain[b3m_pkg::NLIMB].ok
                 && !chain[b3m_pkg::NLIMB].drop;
    end
    if (adv) begin
      out_value <= chain[b3m_pkg::NLIMB].n;
    end
  end

  assign found.valid = out_vld;
  assign found.value = out_value;

endmodule

`default_nettype wire

// File: sv/b3m_chk.sv
`default_nettype none

`include "base3_mask_base57_digit_filter_core_macros.svh"

// Port-level checks on the digit filter
module b3m_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         cand_valid,
  input logic                         cand_ready,
  input logic                         found_valid,
  input logic                         found_ready,
  input logic [b3m_pkg::VALUE_W-1:0]  found_value
);

  // A waiting result stays offered
  `B3M_ASSERT_NEXT(a_found_hold, found_valid && !found_ready, found_valid, "result dropped while stalled")

  // A waiting result keeps its value
  `B3M_ASSERT_NEXT(a_found_stable, found_valid && !found_ready, $stable(found_value), "result changed while stalled")

  // A blocked output stops intake
  `B3M_ASSERT_NOW(a_stall_blocks, found_valid && !found_ready, !cand_ready, "input taken while output stalled")

  // No result exceeds the largest sum of powers of three
  `B3M_ASSERT_NOW(a_value_range, found_valid, found_value <= b3m_pkg::VALUE_MAX, "result out of range")

endmodule

bind base3_mask_base57_digit_filter_core b3m_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .cand_valid  (cand.valid),
  .cand_ready  (cand.ready),
  .found_valid (found.valid),
  .found_ready (found.ready),
  .found_value (found.value)
);

`default_nettype wire
